// ===== src/ledb_pkg.sv =====
// ----------------------------------------------------------------------------
// ledb_pkg
// Shared types and constants of the decimal error-code LED blinker.
// ----------------------------------------------------------------------------
package ledb_pkg;

  localparam int CODE_WIDTH  = 27;
  localparam int CODE_DIGITS = 9;
  localparam int LEN_WIDTH   = 24;
  localparam int CNT_WIDTH   = $clog2(CODE_WIDTH + 1);

  localparam logic [2:0] REG_ERROR_CODE      = 3'd0;
  localparam logic [2:0] REG_BLINK_DISABLED  = 3'd1;
  localparam logic [2:0] REG_SHORT_TICKS     = 3'd2;
  localparam logic [2:0] REG_DIGIT_GAP_TICKS = 3'd3;
  localparam logic [2:0] REG_LONG_ON_TICKS   = 3'd4;
  localparam logic [2:0] REG_CYCLE_GAP_TICKS = 3'd5;
  localparam logic [2:0] REG_ERROR_ON_NORMAL = 3'd6;

  typedef logic [3:0] digit_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_ON_S,
    PH_OFF_S,
    PH_ON_L,
    PH_DGAP,
    PH_CGAP
  } phase_t;

  typedef struct packed {
    logic                 code_zero;
    logic                 blink_disabled;
    logic [LEN_WIDTH-1:0] short_ticks;
    logic [LEN_WIDTH-1:0] digit_gap_ticks;
    logic [LEN_WIDTH-1:0] long_on_ticks;
    logic [LEN_WIDTH-1:0] cycle_gap_ticks;
    logic                 error_on_normal_led;
  } cfg_t;

  typedef struct packed {
    logic   normal_lamp;
    logic   error_lamp;
    digit_t shown_digit;
    logic   round_start;
  } result_t;

endpackage

// ===== src/ledb_bcd_conv.sv =====
// ----------------------------------------------------------------------------
// ledb_bcd_conv
// Shift-and-add-3 converter of the error code to decimal digits, one bit per
// cycle; holds the digits of the last code written.
// ----------------------------------------------------------------------------
module ledb_bcd_conv (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ledb_pkg::CODE_WIDTH-1:0]   code,
  output logic                              busy,
  output ledb_pkg::digit_t                  bcd [ledb_pkg::CODE_DIGITS]
);

  logic [ledb_pkg::CODE_WIDTH-1:0] bin;
  logic [ledb_pkg::CNT_WIDTH-1:0]  cnt;
  ledb_pkg::digit_t                adj [ledb_pkg::CODE_DIGITS];

  always_comb begin
    for (int i = 0; i < ledb_pkg::CODE_DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      bin  <= '0;
      for (int i = 0; i < ledb_pkg::CODE_DIGITS; i++) bcd[i] <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= ledb_pkg::CNT_WIDTH'(ledb_pkg::CODE_WIDTH);
      bin  <= code;
      for (int i = 0; i < ledb_pkg::CODE_DIGITS; i++) bcd[i] <= '0;
    end else if (busy) begin
      bcd[0] <= {adj[0][2:0], bin[ledb_pkg::CODE_WIDTH-1]};
      for (int i = 1; i < ledb_pkg::CODE_DIGITS; i++) begin
        bcd[i] <= {adj[i][2:0], adj[i-1][3]};
      end
      bin <= {bin[ledb_pkg::CODE_WIDTH-2:0], 1'b0};
      cnt <= cnt - ledb_pkg::CNT_WIDTH'(1);
      if (cnt == ledb_pkg::CNT_WIDTH'(1)) busy <= 1'b0;
    end
  end

endmodule

// ===== src/ledb_blink_fsm.sv =====
// ----------------------------------------------------------------------------
// ledb_blink_fsm
// Round and pulse sequencer: advances one tick per request whose tick bit is
// set and forms the LED result of that request.
// ----------------------------------------------------------------------------
module ledb_blink_fsm #(
  parameter int DIGIT_COUNT = 9,
  parameter int TIMER_WIDTH = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              tick,
  input  ledb_pkg::cfg_t    cfg,
  input  ledb_pkg::digit_t  bcd [ledb_pkg::CODE_DIGITS],
  output ledb_pkg::result_t result
);

  localparam logic [TIMER_WIDTH-1:0] ONE = {{(TIMER_WIDTH-1){1'b0}}, 1'b1};

  function automatic logic [TIMER_WIDTH-1:0] len_of(
    input logic [ledb_pkg::LEN_WIDTH-1:0] v
  );
    logic [31:0]            e;
    logic [TIMER_WIDTH-1:0] l;
    e = 32'(v);
    l = e[TIMER_WIDTH-1:0];
    return (l == '0) ? ONE : l;
  endfunction

  ledb_pkg::phase_t       phase, phase_next;
  logic [TIMER_WIDTH-1:0] phase_timer, phase_timer_next;
  logic [3:0]             digits_left, digits_left_next;
  logic [3:0]             pulses_left, pulses_left_next;
  ledb_pkg::digit_t       current_digit, current_digit_next;
  logic                   zero_round, zero_round_next;
  ledb_pkg::digit_t       digits [DIGIT_COUNT];
  ledb_pkg::digit_t       digits_next [DIGIT_COUNT];

  always_comb begin
    ledb_pkg::phase_t       b_phase;
    logic [TIMER_WIDTH-1:0] b_timer;
    logic [3:0]             b_dl;
    logic [3:0]             b_pulses;
    ledb_pkg::digit_t       b_cur;
    logic                   b_zr;
    logic [3:0]             first_dl;
    ledb_pkg::digit_t       first_d;
    ledb_pkg::digit_t       d;
    logic [3:0]             p;
    logic                   begin_round;
    logic                   on;
    logic                   do_end;
    logic                   do_start;

    begin_round = tick && (phase == ledb_pkg::PH_START);
    b_phase  = phase;
    b_timer  = phase_timer;
    b_dl     = digits_left;
    b_pulses = pulses_left;
    b_cur    = current_digit;
    b_zr     = zero_round;
    digits_next = digits;

    first_dl = '0;
    first_d  = '0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (bcd[i] != '0) begin
        first_dl = 4'(i);
        first_d  = bcd[i];
      end
    end

    if (begin_round) begin
      b_zr     = cfg.code_zero;
      b_cur    = '0;
      b_pulses = '0;
      b_dl     = '0;
      for (int i = 0; i < DIGIT_COUNT; i++) digits_next[i] = bcd[i];
      if (cfg.blink_disabled) begin
        b_phase = ledb_pkg::PH_CGAP;
        b_timer = len_of(cfg.cycle_gap_ticks);
      end else if (cfg.code_zero) begin
        b_phase = ledb_pkg::PH_ON_L;
        b_timer = len_of(cfg.long_on_ticks);
      end else begin
        b_dl  = first_dl;
        b_cur = first_d;
        if (first_d != '0) begin
          b_pulses = first_d;
          b_phase  = ledb_pkg::PH_ON_S;
          b_timer  = len_of(cfg.short_ticks);
        end else begin
          b_phase = ledb_pkg::PH_ON_L;
          b_timer = len_of(cfg.long_on_ticks);
        end
      end
    end

    on = (b_phase == ledb_pkg::PH_ON_S) || (b_phase == ledb_pkg::PH_ON_L);
    result.round_start = begin_round;
    result.shown_digit = (on || b_phase == ledb_pkg::PH_OFF_S) ? b_cur : '0;
    result.normal_lamp = on && !cfg.blink_disabled && (b_zr || cfg.error_on_normal_led);
    result.error_lamp  = on && !cfg.blink_disabled && !(b_zr || cfg.error_on_normal_led);

    phase_next         = b_phase;
    phase_timer_next   = b_timer;
    digits_left_next   = b_dl;
    pulses_left_next   = b_pulses;
    current_digit_next = b_cur;
    zero_round_next    = b_zr;
    do_end   = 1'b0;
    do_start = 1'b0;
    d = '0;
    p = '0;

    if (tick && b_phase != ledb_pkg::PH_START) begin
      if (b_timer > ONE) begin
        phase_timer_next = b_timer - ONE;
      end else begin
        unique case (b_phase)
          ledb_pkg::PH_ON_S: begin
            phase_next       = ledb_pkg::PH_OFF_S;
            phase_timer_next = len_of(cfg.short_ticks);
          end
          ledb_pkg::PH_OFF_S: begin
            p = (b_pulses != '0) ? b_pulses - 4'd1 : '0;
            pulses_left_next = p;
            if (p != '0) begin
              phase_next       = ledb_pkg::PH_ON_S;
              phase_timer_next = len_of(cfg.short_ticks);
            end else begin
              do_end = 1'b1;
            end
          end
          ledb_pkg::PH_ON_L: do_end = 1'b1;
          ledb_pkg::PH_DGAP: begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
              if (b_dl == 4'(i + 1)) d = digits[i];
            end
            digits_left_next   = (b_dl != '0) ? b_dl - 4'd1 : '0;
            current_digit_next = d;
            do_start = 1'b1;
          end
          default: begin
            phase_next       = ledb_pkg::PH_START;
            phase_timer_next = '0;
          end
        endcase
      end
    end

    if (do_start) begin
      if (d != '0) begin
        pulses_left_next = d;
        phase_next       = ledb_pkg::PH_ON_S;
        phase_timer_next = len_of(cfg.short_ticks);
      end else begin
        phase_next       = ledb_pkg::PH_ON_L;
        phase_timer_next = len_of(cfg.long_on_ticks);
      end
    end

    if (do_end) begin
      current_digit_next = '0;
      if (!b_zr && b_dl != '0) begin
        phase_next       = ledb_pkg::PH_DGAP;
        phase_timer_next = len_of(cfg.digit_gap_ticks);
      end else begin
        phase_next       = ledb_pkg::PH_CGAP;
        phase_timer_next = len_of(cfg.cycle_gap_ticks);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ledb_pkg::PH_START;
      phase_timer   <= '0;
      digits_left   <= '0;
      pulses_left   <= '0;
      current_digit <= '0;
      zero_round    <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      phase_timer   <= phase_timer_next;
      digits_left   <= digits_left_next;
      pulses_left   <= pulses_left_next;
      current_digit <= current_digit_next;
      zero_round    <= zero_round_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      digits <= digits_next;
    end
  end

endmodule

// ===== src/led_decimal_error_code_blinker_core.sv =====
// ----------------------------------------------------------------------------
// led_decimal_error_code_blinker_core
// Shows a configured error code as decimal digit blinks on two LEDs.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the in channel carries one tick bit; tick=1 advances the
//   blink timing by one tick, tick=0 holds it. Every request yields exactly
//   one result on the out channel: the LED drives, the digit being shown and
//   a round-start flag for that tick.
//   Each result is registered; one request is taken per cycle while in_stall
//   is low. A two-entry output buffer lets a request be taken while a result
//   waits; in_stall rises when both entries are full.
//   Writing error_code starts a digit conversion, one code bit per cycle;
//   during it cfg_ready is low and in_stall is high.
//   Configuration registers are indexed 0..6 on cfg_index; other indexes are
//   dropped. Lengths are read live; error_code is taken at each round start;
//   blink_disabled is checked at each round start and also gates the lamps live.
//   Reset (rst, synchronous) restores the register defaults, empties the
//   output buffer and arms a new round for the first tick.
// ----------------------------------------------------------------------------
module led_decimal_error_code_blinker_core #(
  parameter int DIGIT_COUNT = 9,
  parameter int TIMER_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        normal_lamp,
  output logic        error_lamp,
  output logic [3:0]  shown_digit,
  output logic        round_start,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [26:0] cfg_data
);

  logic [ledb_pkg::CODE_WIDTH-1:0] error_code;
  logic                            blink_disabled;
  logic [ledb_pkg::LEN_WIDTH-1:0]  short_ticks;
  logic [ledb_pkg::LEN_WIDTH-1:0]  digit_gap_ticks;
  logic [ledb_pkg::LEN_WIDTH-1:0]  long_on_ticks;
  logic [ledb_pkg::LEN_WIDTH-1:0]  cycle_gap_ticks;
  logic                            error_on_normal_led;
  ledb_pkg::cfg_t                  cfg;
  logic                            conv_busy;
  logic                            conv_start;
  logic                            cfg_write;
  logic                            step;
  logic                            take;
  ledb_pkg::digit_t                bcd [ledb_pkg::CODE_DIGITS];
  ledb_pkg::result_t               result;
  ledb_pkg::result_t               out_q;
  ledb_pkg::result_t               skid_q;
  logic                            skid_valid;

  assign cfg_ready  = !conv_busy;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign conv_start = cfg_write && (cfg_index == ledb_pkg::REG_ERROR_CODE);
  assign in_stall   = skid_valid || conv_busy;
  assign step       = in_valid && !in_stall;
  assign take       = out_valid && !out_stall;

  always_comb begin
    cfg.code_zero           = (error_code == '0);
    cfg.blink_disabled      = blink_disabled;
    cfg.short_ticks         = short_ticks;
    cfg.digit_gap_ticks     = digit_gap_ticks;
    cfg.long_on_ticks       = long_on_ticks;
    cfg.cycle_gap_ticks     = cycle_gap_ticks;
    cfg.error_on_normal_led = error_on_normal_led;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_code          <= '0;
      blink_disabled      <= 1'b0;
      short_ticks         <= 24'd200;
      digit_gap_ticks     <= 24'd500;
      long_on_ticks       <= 24'd1000;
      cycle_gap_ticks     <= 24'd1000;
      error_on_normal_led <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ledb_pkg::REG_ERROR_CODE:      error_code <= cfg_data;
        ledb_pkg::REG_BLINK_DISABLED:  blink_disabled <= cfg_data[0];
        ledb_pkg::REG_SHORT_TICKS:     short_ticks <= cfg_data[23:0];
        ledb_pkg::REG_DIGIT_GAP_TICKS: digit_gap_ticks <= cfg_data[23:0];
        ledb_pkg::REG_LONG_ON_TICKS:   long_on_ticks <= cfg_data[23:0];
        ledb_pkg::REG_CYCLE_GAP_TICKS: cycle_gap_ticks <= cfg_data[23:0];
        ledb_pkg::REG_ERROR_ON_NORMAL: error_on_normal_led <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ledb_bcd_conv u_conv (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .code  (cfg_data),
    .busy  (conv_busy),
    .bcd   (bcd)
  );

  ledb_blink_fsm #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_fsm (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .tick   (tick),
    .cfg    (cfg),
    .bcd    (bcd),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= step;
      end else begin
        out_valid <= step;
      end
    end else if (step) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_q  <= skid_q;
        skid_q <= result;
      end else begin
        out_q <= result;
      end
    end else if (step) begin
      skid_q <= result;
    end
  end

  assign normal_lamp = out_q.normal_lamp;
  assign error_lamp  = out_q.error_lamp;
  assign shown_digit = out_q.shown_digit;
  assign round_start = out_q.round_start;

endmodule
